// File: hdl/pwss_pkg.sv
// ----------------------------------------------------------------------------
// pwss_pkg
// Shared types and constants of the priority work-stealing scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pwss_pkg;

    // field widths
    localparam int ID_W          = 16;
    localparam int SIZE_W        = 14;
    localparam int WORKER_W      = 3;
    localparam int MAX_SIZE_W    = 14;
    localparam int LIMIT_W       = 8;
    // widest level code, enough for sixteen levels
    localparam int LEVEL_FIELD_W = 4;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int S_TDATA_W     = 40;
    localparam int M_TDATA_W     = 40;

    // register values after reset
    localparam logic [MAX_SIZE_W-1:0] RESET_MAX_SIZE    = 14'd10000;
    localparam logic [LIMIT_W-1:0]    RESET_QUEUE_LIMIT = 8'd100;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0]
    {
        REG_MAX_SIZE    = 2'd0,
        REG_QUEUE_LIMIT = 2'd1
    } reg_index_t;

    typedef enum logic
    {
        CMD_NEW_JOB = 1'b0,
        CMD_REQUEST = 1'b1
    } cmd_t;

    typedef enum logic
    {
        RES_DISPATCH = 1'b0,
        RES_REJECT   = 1'b1
    } res_kind_t;

    // classified item from the front to the back
    typedef struct packed
    {
        cmd_t                     cmd;
        logic [ID_W-1:0]          id;
        logic [SIZE_W-1:0]        size;
        logic [WORKER_W-1:0]      worker;
        logic [LEVEL_FIELD_W-1:0] level;
    } item_t;

    // one result beat
    typedef struct packed
    {
        res_kind_t           kind;
        logic [ID_W-1:0]     id;
        logic [SIZE_W-1:0]   size;
        logic [WORKER_W-1:0] target;
        logic [WORKER_W-1:0] source;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/pwss_front.sv
// ----------------------------------------------------------------------------
// pwss_front
// Accepts input beats and picks the priority level of a new job with a
// bit-serial restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module pwss_front #(
    parameter int NUM_LEVELS = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire pwss_pkg::cmd_t                 in_cmd,
    input  wire logic [pwss_pkg::ID_W-1:0]      in_id,
    input  wire logic [pwss_pkg::SIZE_W-1:0]    in_size,
    input  wire logic [pwss_pkg::WORKER_W-1:0]  in_worker,
    input  wire logic [pwss_pkg::MAX_SIZE_W-1:0] max_size,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output pwss_pkg::item_t                     out_item
);
    import pwss_pkg::*;

    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int NUM_W  = SIZE_W + LVL_W;
    localparam int STEP_W = $clog2(NUM_W);
    localparam int REM_W  = MAX_SIZE_W + 1;

    typedef enum logic [2:0]
    {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t            state_reg, state_next;
    item_t              item_reg, item_next;
    logic [NUM_W-1:0]   qr_reg, qr_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    logic [REM_W-1:0]   divisor;
    logic [REM_W:0]     trial;
    logic               fits;
    logic [REM_W:0]     rem_step;
    logic [NUM_W-1:0]   qr_step;
    logic [LVL_W-1:0]   band_level;
    logic               oversize;

    // one quotient bit per cycle
    assign divisor    = {1'b0, max_size} + REM_W'(1);
    assign trial      = {rem_reg, qr_reg[NUM_W-1]};
    assign fits       = trial >= {1'b0, divisor};
    assign rem_step   = fits ? (trial - {1'b0, divisor}) : trial;
    assign qr_step    = {qr_reg[NUM_W-2:0], fits};
    assign band_level = LVL_W'(NUM_LEVELS - 1) - qr_step[LVL_W-1:0];
    assign oversize   = in_size > max_size;

    assign in_ready  = (state_reg == F_IDLE);
    assign out_valid = (state_reg == F_PUSH);
    assign out_item  = item_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        qr_next    = qr_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    item_next.cmd    = in_cmd;
                    item_next.id     = in_id;
                    item_next.size   = in_size;
                    item_next.worker = in_worker;
                    item_next.level  = '0;
                    qr_next          = NUM_W'(int'(in_size) * NUM_LEVELS);
                    rem_next         = '0;
                    step_next        = '0;
                    if (in_cmd == CMD_NEW_JOB && !oversize)
                    begin
                        state_next = F_DIV;
                    end
                    else
                    begin
                        // oversized jobs go to the lowest level
                        state_next = F_PUSH;
                    end
                end
            end
            F_DIV:
            begin
                qr_next   = qr_step;
                rem_next  = rem_step[REM_W-1:0];
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    item_next.level = LEVEL_FIELD_W'(band_level);
                    state_next      = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (out_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        qr_reg   <= qr_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
    end

endmodule

`default_nettype wire

// File: hdl/pwss_queue.sv
// ----------------------------------------------------------------------------
// pwss_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pwss_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire pwss_pkg::item_t in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output pwss_pkg::item_t      out_item
);
    import pwss_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// File: hdl/pwss_back.sv
// ----------------------------------------------------------------------------
// pwss_back
// Per-level job FIFOs in one memory, worker state and the dispatch / steal
// scan; results leave through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pwss_back #(
    parameter int NUM_LEVELS = 8,
    parameter int FIFO_DEPTH = 128
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_valid,
    output logic                              q_ready,
    input  wire pwss_pkg::item_t              q_item,
    input  wire logic [pwss_pkg::LIMIT_W-1:0] queue_limit,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output pwss_pkg::result_t                 res
);
    import pwss_pkg::*;

    localparam int LVL_W   = $clog2(NUM_LEVELS);
    localparam int PTR_W   = $clog2(FIFO_DEPTH);
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int ADDR_W  = $clog2(NUM_LEVELS * FIFO_DEPTH);
    localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int ENTRY_W = ID_W + SIZE_W;
    localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(FIFO_DEPTH);

    typedef enum logic [1:0]
    {
        B_IDLE = 2'b01,
        B_READ = 2'b10
    } bstate_t;

    bstate_t               state_reg, state_next;
    logic [PTR_W-1:0]      head_reg [NUM_LEVELS];
    logic [PTR_W-1:0]      head_next [NUM_LEVELS];
    logic [CNT_W-1:0]      count_reg [NUM_LEVELS];
    logic [CNT_W-1:0]      count_next [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] free_reg, free_next;
    logic                  res_valid_reg, res_valid_next;
    result_t               res_reg, res_next;
    logic [WORKER_W-1:0]   target_reg, target_next;
    logic [WORKER_W-1:0]   source_reg, source_next;
    logic [ENTRY_W-1:0]    job_store_reg [NUM_LEVELS * FIFO_DEPTH];
    logic [ENTRY_W-1:0]    rd_data_reg;

    logic                  take;
    logic [LVL_W-1:0]      lvl, wlvl, pick;
    logic                  w_ok, found, full;
    logic [CNT_W-1:0]      cnt_l;
    logic [PTR_W-1:0]      head_l, head_p, tail;
    logic [CNT_W:0]        tail_sum;
    logic                  mem_we, rd_en;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;

    assign q_ready   = (state_reg == B_IDLE) && !res_valid_reg;
    assign take      = q_ready && q_valid;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // arriving job: level state and tail slot
    assign lvl      = q_item.level[LVL_W-1:0];
    assign cnt_l    = count_reg[lvl];
    assign head_l   = head_reg[lvl];
    assign full     = (CMP_W'(cnt_l) >= CMP_W'(queue_limit))
                   || (CMP_W'(cnt_l) >= CMP_W'(FIFO_DEPTH));
    assign tail_sum = (CNT_W + 1)'(head_l) + (CNT_W + 1)'(cnt_l);
    assign tail     = (tail_sum >= (CNT_W + 1)'(FIFO_DEPTH))
                    ? PTR_W'(tail_sum - (CNT_W + 1)'(FIFO_DEPTH)) : PTR_W'(tail_sum);
    assign wr_addr  = ADDR_W'(lvl) * DEPTH_A + ADDR_W'(tail);

    // work request: first non-empty level at or above the worker
    assign w_ok = (32'(q_item.worker) < NUM_LEVELS);
    assign wlvl = LVL_W'(q_item.worker);

    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0 && LVL_W'(i) >= wlvl)
            begin
                found = 1'b1;
                pick  = LVL_W'(i);
            end
        end
    end

    assign head_p  = head_reg[pick];
    assign rd_addr = ADDR_W'(pick) * DEPTH_A + ADDR_W'(head_p);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        free_next      = free_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        target_next    = target_reg;
        source_next    = source_reg;
        mem_we         = 1'b0;
        rd_en          = 1'b0;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (take)
                begin
                    if (q_item.cmd == CMD_NEW_JOB)
                    begin
                        if (full)
                        begin
                            res_valid_next = 1'b1;
                            res_next = '{kind: RES_REJECT, id: q_item.id,
                                         size: '0, target: '0, source: '0};
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            if (cnt_l == '0 && free_reg[lvl])
                            begin
                                // empty level, free worker: straight through
                                head_next[lvl] = (head_l == PTR_W'(FIFO_DEPTH - 1))
                                               ? '0 : head_l + PTR_W'(1);
                                free_next[lvl] = 1'b0;
                                res_valid_next = 1'b1;
                                res_next = '{kind: RES_DISPATCH, id: q_item.id,
                                             size: q_item.size,
                                             target: WORKER_W'(lvl),
                                             source: WORKER_W'(lvl)};
                            end
                            else
                            begin
                                count_next[lvl] = cnt_l + CNT_W'(1);
                            end
                        end
                    end
                    else if (w_ok)
                    begin
                        free_next[wlvl] = 1'b1;
                        if (found)
                        begin
                            rd_en           = 1'b1;
                            head_next[pick] = (head_p == PTR_W'(FIFO_DEPTH - 1))
                                            ? '0 : head_p + PTR_W'(1);
                            count_next[pick] = count_reg[pick] - CNT_W'(1);
                            free_next[wlvl] = 1'b0;
                            target_next     = q_item.worker;
                            source_next     = WORKER_W'(pick);
                            state_next      = B_READ;
                        end
                    end
                end
            end
            B_READ:
            begin
                // memory data arrives this cycle
                res_valid_next = 1'b1;
                res_next = '{kind: RES_DISPATCH, id: rd_data_reg[ID_W-1:0],
                             size: rd_data_reg[ENTRY_W-1:ID_W],
                             target: target_reg, source: source_reg};
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            free_reg      <= '1;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            res_valid_reg <= res_valid_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        target_reg <= target_next;
        source_reg <= source_next;
    end

    // job store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            job_store_reg[wr_addr] <= {q_item.size, q_item.id};
        end
        if (rd_en)
        begin
            rd_data_reg <= job_store_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/priority_work_stealing_scheduler_top.sv
// ----------------------------------------------------------------------------
// priority_work_stealing_scheduler_top
// Schedules jobs onto one worker per priority level; a free worker steals
// waiting jobs from its own level or any higher one.
// ----------------------------------------------------------------------------
//
//  channel   direction  beat contents
//  s_axis    in         tuser: command; tdata: job_id, job_size, worker
//  m_axis    out        tuser: result_kind; tdata: out_id, out_size,
//                       target_worker, source_level
//  cfg       in         cfg_index: register, cfg_data: value
//
//  new job: accept, serial divider, hand-off to the queue, then the back;
//  a work request skips the divider and, when it takes a queued job, also
//  passes the registered read port of the job store.
//  the input side takes one beat at a time, busy through divider and hand-off.
//  reset clears the level pointers and counts and marks every worker free
//  at once; the job store needs no clearing.
//  a waiting result stalls the back only; the front keeps filling the queue.
//
`default_nettype none

module priority_work_stealing_scheduler_top #(
    parameter int NUM_LEVELS  = 8,
    parameter int FIFO_DEPTH  = 128,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [15:0] job_id, [29:16] job_size, [32:30] worker, [39:33] zero
    input  wire logic [pwss_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [0] command
    input  wire logic                              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [15:0] out_id, [29:16] out_size, [32:30] target_worker,
    // [35:33] source_level, [39:36] zero
    output logic [pwss_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    // [0] result_kind
    output logic                                   m_axis_tuser,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pwss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [pwss_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pwss_pkg::*;

    logic [MAX_SIZE_W-1:0] max_size_reg;
    logic [LIMIT_W-1:0]    queue_limit_reg;

    logic    fr_valid, fr_ready;
    item_t   fr_item;
    logic    bk_valid, bk_ready;
    item_t   bk_item;
    logic    res_valid;
    result_t res;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_size_reg    <= RESET_MAX_SIZE;
            queue_limit_reg <= RESET_QUEUE_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_MAX_SIZE)
            begin
                max_size_reg <= cfg_data[MAX_SIZE_W-1:0];
            end
            else if (cfg_index == REG_QUEUE_LIMIT)
            begin
                queue_limit_reg <= cfg_data[LIMIT_W-1:0];
            end
        end
    end

    // front: classify
    pwss_front #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (cmd_t'(s_axis_tuser)),
        .in_id     (s_axis_tdata[15:0]),
        .in_size   (s_axis_tdata[29:16]),
        .in_worker (s_axis_tdata[32:30]),
        .max_size  (max_size_reg),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    // decoupling queue
    pwss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_item  (bk_item)
    );

    // back: level FIFOs and dispatch
    pwss_back #(
        .NUM_LEVELS (NUM_LEVELS),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (bk_valid),
        .q_ready     (bk_ready),
        .q_item      (bk_item),
        .queue_limit (queue_limit_reg),
        .res_valid   (res_valid),
        .res_ready   (m_axis_tready),
        .res         (res)
    );

    // result beat
    assign m_axis_tvalid = res_valid;
    assign m_axis_tuser  = res.kind;
    assign m_axis_tdata  = {4'b0, res.source, res.target, res.size, res.id};

    // the front takes one beat and then goes busy
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("front accepted two beats back to back");

    // a rejected job carries no size or levels
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == RES_REJECT |-> m_axis_tdata[35:16] == '0)
    else $error("reject result with non-zero fields");

    // jobs are only taken from the worker's own level or above
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == RES_DISPATCH
        |-> (NUM_LEVELS > 8) || (m_axis_tdata[35:33] >= m_axis_tdata[32:30]))
    else $error("job stolen from a lower level");

    // the back never starts an item while a result still waits
    assert property (@(posedge clk) disable iff (!rst_n)
        bk_valid && bk_ready |-> !m_axis_tvalid)
    else $error("back took an item with the output register full");

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the priority work-stealing scheduler against a cycle-free predictor.
// Directed beats cover level placement, oversized and zero-bound sizes,
// stealing from higher levels and rejection. A saturation run fills one level
// past its depth. Random traffic then runs under several register settings.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------

module tb;

    import pwss_pkg::*;

    localparam int unsigned LEVELS        = 8;
    localparam int unsigned DEPTH         = 128;
    // cycles for in-flight jobs that give no result to leave the pipe
    localparam int unsigned SETTLE_CYCLES = 200;

    // indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    // predictor state
    logic [MAX_SIZE_W-1:0]  max_size_q;
    logic [LIMIT_W-1:0]     queue_limit_q;
    logic [ID_W-1:0]        slot_id   [LEVELS][DEPTH];
    logic [SIZE_W-1:0]      slot_size [LEVELS][DEPTH];
    int unsigned            lvl_head  [LEVELS];
    int unsigned            lvl_count [LEVELS];
    bit                     worker_idle [LEVELS];

    result_t                due_results[$];
    int unsigned            mismatch_count = 0;
    bit                     quiet = 1'b0;

    priority_work_stealing_scheduler_top #(
        .NUM_LEVELS (LEVELS),
        .FIFO_DEPTH (DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // small sizes land high, sizes past the bound clamp to level 0
    function automatic int unsigned level_for_size(input logic [SIZE_W-1:0] sz);
        int unsigned band;
        if (sz > max_size_q)
            return 0;
        band = (32'(sz) * LEVELS) / (32'(max_size_q) + 1);
        return (band >= LEVELS) ? 0 : LEVELS - 1 - band;
    endfunction

    function automatic void pop_job(input int unsigned lvl, input int unsigned wk,
                                    output result_t res);
        res.kind   = RES_DISPATCH;
        res.id     = slot_id[lvl][lvl_head[lvl]];
        res.size   = slot_size[lvl][lvl_head[lvl]];
        res.target = 3'(wk);
        res.source = 3'(lvl);
        lvl_head[lvl]  = (lvl_head[lvl] + 1) % DEPTH;
        lvl_count[lvl] = lvl_count[lvl] - 1;
    endfunction

    // advances the scheduler state by one beat, returns 1 when a result is due
    function automatic bit schedule_item(input cmd_t cmd, input logic [ID_W-1:0] id,
                                         input logic [SIZE_W-1:0] sz,
                                         input logic [WORKER_W-1:0] wk,
                                         output result_t res);
        int unsigned lvl;
        int unsigned cap;
        int unsigned tail;
        int unsigned p;
        res = '0;
        if (cmd == CMD_NEW_JOB)
        begin
            lvl = level_for_size(sz);
            cap = (queue_limit_q > DEPTH) ? DEPTH : queue_limit_q;
            if (lvl_count[lvl] >= cap)
            begin
                res.kind = RES_REJECT;
                res.id   = id;
                return 1'b1;
            end
            tail = (lvl_head[lvl] + lvl_count[lvl]) % DEPTH;
            slot_id[lvl][tail]   = id;
            slot_size[lvl][tail] = sz;
            lvl_count[lvl]       = lvl_count[lvl] + 1;
            // dispatch at once only into an empty level with a free worker
            if (lvl_count[lvl] != 1 || !worker_idle[lvl])
                return 1'b0;
            worker_idle[lvl] = 1'b0;
            pop_job(lvl, lvl, res);
            return 1'b1;
        end
        // work request: own level first, then every higher one
        worker_idle[wk] = 1'b1;
        for (p = wk; p < LEVELS; p++)
        begin
            if (lvl_count[p] != 0)
            begin
                pop_job(p, wk, res);
                worker_idle[wk] = 1'b0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // result side: check each beat against the next expected result
    task automatic check_result();
        result_t want;
        result_t got;
        got.kind   = res_kind_t'(m_axis_tuser);
        got.id     = m_axis_tdata[15:0];
        got.size   = m_axis_tdata[29:16];
        got.target = m_axis_tdata[32:30];
        got.source = m_axis_tdata[35:33];
        if (due_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result beat at %0t: kind %0d id %h", $realtime,
                         got.kind, got.id);
        end
        else
        begin
            want = due_results.pop_front();
            if (got.kind !== want.kind || got.id !== want.id || got.size !== want.size ||
                got.target !== want.target || got.source !== want.source)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch at %0t:", $realtime,
                             " expected kind %0d id %h size %0d target %0d source %0d,",
                             want.kind, want.id, want.size, want.target, want.source,
                             " got kind %0d id %h size %0d target %0d source %0d",
                             got.kind, got.id, got.size, got.target, got.source);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_result();
        m_axis_tready <= quiet || ($urandom_range(99) >= 18);
    end

    // one input beat; entered and left right after a rising edge
    task automatic send_item(input cmd_t cmd, input logic [ID_W-1:0] id,
                             input logic [SIZE_W-1:0] sz, input logic [WORKER_W-1:0] wk);
        result_t res;
        if (!quiet && $urandom_range(99) < 18)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(24, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'd0, wk, sz, id};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (schedule_item(cmd, id, sz, wk, res))
            due_results.push_back(res);
    endtask

    task automatic send_job(input logic [ID_W-1:0] id, input logic [SIZE_W-1:0] sz);
        send_item(CMD_NEW_JOB, id, sz, 3'($urandom));
    endtask

    task automatic send_request(input logic [WORKER_W-1:0] wk);
        send_item(CMD_REQUEST, 16'($urandom), 14'($urandom), wk);
    endtask

    // config beat; cfg_valid stays high for a following beat
    task automatic write_reg_beat(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] word);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_MAX_SIZE)
            max_size_q = word[MAX_SIZE_W-1:0];
        else if (idx == REG_QUEUE_LIMIT)
            queue_limit_q = word[LIMIT_W-1:0];
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] size_word,
                             input logic [CFG_DATA_W-1:0] limit_word);
        write_reg_beat(REG_MAX_SIZE, size_word);
        write_reg_beat(REG_QUEUE_LIMIT, limit_word);
        cfg_valid <= 1'b0;
    endtask

    // drain expected results, then let silent jobs leave the pipe
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // reset settings: placement, stealing upward, busy and empty requests
    task automatic test_placement();
        send_job(16'h0000, 14'd0);
        send_job(16'hFFFF, 14'd16383);
        send_job(16'h0103, 14'd10000);
        send_job(16'h0104, 14'd10001);
        send_request(3'd0);
        send_request(3'd7);
        send_job(16'h0107, 14'd1251);
        send_job(16'h0108, 14'd1252);
        send_request(3'd3);
        send_request(3'd0);
        send_request(3'd5);
    endtask

    // narrowest, zero and widest size bounds
    task automatic test_band_edges();
        wait_idle();
        configure(16'd1, 16'd100);
        send_job(16'h0201, 14'd1);
        send_job(16'h0202, 14'd2);
        wait_idle();
        configure(16'd0, 16'd100);
        send_job(16'h0203, 14'd0);
        send_job(16'h0204, 14'd1);
        wait_idle();
        configure(16'd16383, 16'd100);
        send_job(16'h0205, 14'd16383);
        send_job(16'h0206, 14'd2047);
        send_job(16'h0207, 14'd2048);
    endtask

    // zero limit, ignored spare registers, limit of one
    task automatic test_queue_limits();
        wait_idle();
        configure(16'd10000, 16'd0);
        send_job(16'h0301, 14'd3);
        wait_idle();
        write_reg_beat(REG_SPARE_2, 16'hFFFF);
        write_reg_beat(REG_SPARE_3, 16'h0000);
        cfg_valid <= 1'b0;
        send_job(16'h0302, 14'd3);
        wait_idle();
        configure(16'd10000, 16'd1);
        send_job(16'h0303, 14'd5000);
        send_job(16'h0304, 14'd5000);
        send_job(16'h0305, 14'd5000);
    endtask

    // limit above depth saturates; the top level fills and its pointer wraps
    task automatic test_fifo_saturation();
        int unsigned n;
        wait_idle();
        configure(16'd16383, 16'd255);
        for (n = 0; n < 136; n++)
            send_job(16'($urandom), 14'($urandom_range(2047, 0)));
    endtask

    task automatic send_random_item();
        logic [SIZE_W-1:0] sz;
        if ($urandom_range(99) < 58)
        begin
            if ($urandom_range(99) < 75)
                sz = 14'($urandom_range(32'(max_size_q), 0));
            else
                sz = 14'($urandom);
            send_job(16'($urandom), sz);
        end
        else
            send_request(3'($urandom));
    endtask

    // random traffic over several settings, one phase with no idling
    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned n;
        for (phase = 0; phase < 8; phase++)
        begin
            wait_idle();
            case (phase)
                0: configure(16'd16383, 16'd128);
                1: configure(16'd1, 16'd1);
                2: configure({2'($urandom), 14'($urandom_range(16383, 1))},
                             {8'($urandom), 8'($urandom_range(8, 1))});
                3: configure(16'd10000, 16'd255);
                4: configure(16'd0, 16'd2);
                5: configure({2'($urandom), 14'($urandom_range(16383, 1))},
                             16'($urandom_range(128, 1)));
                6: configure(16'($urandom_range(16383, 1)), 16'($urandom_range(255, 0)));
                default: configure(16'($urandom_range(16383, 1)), 16'd4);
            endcase
            quiet = (phase == 6);
            for (n = 0; n < 60; n++)
                send_random_item();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        max_size_q    = RESET_MAX_SIZE;
        queue_limit_q = RESET_QUEUE_LIMIT;
        for (int i = 0; i < LEVELS; i++)
        begin
            lvl_head[i]    = 0;
            lvl_count[i]   = 0;
            worker_idle[i] = 1'b1;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_placement();
        test_band_edges();
        test_queue_limits();
        test_fifo_saturation();
        test_random_traffic();
        wait_idle();

        if (mismatch_count == 0)
            $display("[priority_work_stealing_scheduler_top] OK");
        else
            $display("[priority_work_stealing_scheduler_top] ERROR");
        $finish;
    end

    // hang guard
    initial
    begin
        #5ms;
        $display("[priority_work_stealing_scheduler_top] ERROR");
        $finish;
    end

endmodule
